// ===== design/eds_pkg.sv =====
// shared types, constants and register codes of the escaped delimiter splitter
package eds_pkg;

  // window depth in bytes and depth of the queue between front and back
  localparam int MAX_PATTERN_BYTES = 8;
  localparam int QUEUE_DEPTH       = 4;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_DELIM_PATTERN  = 2'd0,
    CFG_DELIM_LENGTH   = 2'd1,
    CFG_ESCAPE_PATTERN = 2'd2,
    CFG_ESCAPE_LENGTH  = 2'd3
  } cfg_index_t;

  // configuration register contents
  typedef struct packed {
    logic [63:0] delimiter_pattern;
    logic [3:0]  delimiter_length;
    logic [63:0] escape_pattern;
    logic [3:0]  escape_length;
  } cfg_t;

  // input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       has_byte;
    logic       string_end;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       piece_end;
    logic       list_last;
  } out_word_t;

endpackage

// ===== design/eds_fifo.sv =====
// small register queue between the front and the back
module eds_fifo
  import eds_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_word_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output in_word_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  in_word_t         mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/eds_front.sv =====
// front: accepts input words and drops those that carry neither byte nor end
module eds_front
  import eds_pkg::*;
(
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  output logic     q_push,
  output in_word_t q_data,
  input  logic     q_full
);

  logic accept;
  logic useful;

  // accept whenever the queue has room
  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  // a word with no byte and no end changes nothing
  assign useful = in_data.has_byte || in_data.string_end;
  assign q_push = accept && useful;

  // zero the byte of a bare end marker
  always_comb begin
    q_data = in_data;
    if (!in_data.has_byte) begin
      q_data.in_byte = '0;
    end
  end

endmodule

// ===== design/eds_back.sv =====
// back: lookahead window, escape and delimiter matching, result register
module eds_back
  import eds_pkg::*;
#(
  parameter int NB = MAX_PATTERN_BYTES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  in_word_t  q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int FW = $clog2(NB + 1);

  logic [7:0]    win_r [NB];
  logic [7:0]    win_nxt [NB];
  logic [7:0]    wv [NB];
  logic [7:0]    shifted [NB];
  logic [FW-1:0] fill_r, fill_nxt, fv;
  logic [FW-1:0] esc_left_r, esc_left_nxt;
  logic          skip_r, skip_nxt;
  logic          drain_r, drain_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_data_r, out_data_nxt;

  logic [FW-1:0] esc_c, del_c, drop_k;
  logic          step, pop, ending;
  logic          do_decide, do_cont, do_final;
  logic          esc_hit, del_hit;

  // clamp pattern lengths to the window depth; a zero delimiter length counts as one
  always_comb begin
    esc_c = (cfg.escape_length > 4'(NB)) ? FW'(NB) : FW'(cfg.escape_length);
    if (cfg.delimiter_length > 4'(NB)) begin
      del_c = FW'(NB);
    end else if (cfg.delimiter_length == '0) begin
      del_c = FW'(1);
    end else begin
      del_c = FW'(cfg.delimiter_length);
    end
  end

  // step control: one result per cycle when the output register is free
  assign step   = !out_valid_r || out_ready;
  assign pop    = step && q_valid && (esc_left_r == '0) && !drain_r;
  assign q_pop  = pop;
  assign ending = drain_r || (pop && q_data.string_end);

  // window as seen this cycle, with the popped byte appended
  always_comb begin
    for (int i = 0; i < NB; i++) begin
      wv[i] = win_r[i];
    end
    fv = fill_r;
    if (pop && q_data.has_byte && (fill_r < FW'(NB))) begin
      for (int i = 0; i < NB; i++) begin
        if (fill_r == FW'(i)) begin
          wv[i] = q_data.in_byte;
        end
      end
      fv = fill_r + 1'b1;
    end
  end

  // parallel compare of the window head against both patterns
  always_comb begin
    esc_hit = (esc_c != '0) && (esc_c <= fv);
    del_hit = (del_c <= fv);
    for (int i = 0; i < NB; i++) begin
      if ((i < int'(esc_c)) && (wv[i] != cfg.escape_pattern[8*i +: 8])) begin
        esc_hit = 1'b0;
      end
      if ((i < int'(del_c)) && (wv[i] != cfg.delimiter_pattern[8*i +: 8])) begin
        del_hit = 1'b0;
      end
    end
  end

  // what this cycle does
  assign do_cont   = step && (esc_left_r != '0);
  assign do_decide = step && (esc_left_r == '0) &&
                     ((pop && !q_data.string_end && (fv == FW'(NB))) ||
                      (ending && (fv != '0)));
  assign do_final  = step && (esc_left_r == '0) && ending && (fv == '0);

  // decision, byte count to drop and result
  always_comb begin
    drop_k        = '0;
    skip_nxt      = skip_r;
    esc_left_nxt  = esc_left_r;
    drain_nxt     = drain_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (do_cont) begin
      // rest of an escape sequence, passed through untested
      drop_k       = FW'(1);
      esc_left_nxt = esc_left_r - 1'b1;
      if (esc_left_r == FW'(1)) begin
        skip_nxt = 1'b1;
      end
      out_data_nxt  = '{out_byte: wv[0], byte_valid: 1'b1, piece_end: 1'b0, list_last: 1'b0};
      out_valid_nxt = 1'b1;
    end else if (do_decide) begin
      out_valid_nxt = 1'b1;
      priority if (skip_r) begin
        // byte after an escape
        drop_k       = FW'(1);
        skip_nxt     = 1'b0;
        out_data_nxt = '{out_byte: wv[0], byte_valid: 1'b1, piece_end: 1'b0,
                         list_last: 1'b0};
      end else if (esc_hit) begin
        drop_k       = FW'(1);
        if (esc_c == FW'(1)) begin
          skip_nxt = 1'b1;
        end else begin
          esc_left_nxt = esc_c - 1'b1;
        end
        out_data_nxt = '{out_byte: wv[0], byte_valid: 1'b1, piece_end: 1'b0,
                         list_last: 1'b0};
      end else if (del_hit) begin
        drop_k       = del_c;
        out_data_nxt = '{out_byte: 8'd0, byte_valid: 1'b0, piece_end: 1'b1,
                         list_last: 1'b0};
      end else begin
        drop_k       = FW'(1);
        out_data_nxt = '{out_byte: wv[0], byte_valid: 1'b1, piece_end: 1'b0,
                         list_last: 1'b0};
      end
    end else if (do_final) begin
      // close the final piece of the string
      skip_nxt      = 1'b0;
      out_data_nxt  = '{out_byte: 8'd0, byte_valid: 1'b0, piece_end: 1'b1, list_last: 1'b1};
      out_valid_nxt = 1'b1;
    end

    if (do_final) begin
      drain_nxt = 1'b0;
    end else if (pop && q_data.string_end) begin
      drain_nxt = 1'b1;
    end
  end

  // drop decided bytes from the window head
  always_comb begin
    for (int i = 0; i < NB; i++) begin
      shifted[i] = 8'd0;
      for (int j = 0; j < NB; j++) begin
        if ((j >= i) && ((j - i) == int'(drop_k))) begin
          shifted[i] = wv[j];
        end
      end
    end
  end

  // next window and fill
  always_comb begin
    for (int i = 0; i < NB; i++) begin
      win_nxt[i] = do_final ? 8'd0 : shifted[i];
    end
    if (do_final) begin
      fill_nxt = '0;
    end else begin
      fill_nxt = fv - drop_k;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      esc_left_r  <= '0;
      skip_r      <= 1'b0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      esc_left_r  <= esc_left_nxt;
      skip_r      <= skip_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // window bytes and result payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < NB; i++) begin
      win_r[i] <= win_nxt[i];
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/escaped_delimiter_splitter.sv =====
// top level of the escaped delimiter splitter: config registers and the front/back split
//
// Splits a byte string on a multi-byte delimiter, honoring an escape string.
// Input channel in_valid/in_ready/in_data: one word per byte of the string,
// string_end set on the last word; a word with has_byte clear and string_end
// set is a bare end marker. Result channel out_valid/out_ready/out_data:
// one word per piece byte or piece end; the last piece end has list_last set.
// Config port cfg_we/cfg_index/cfg_data: write only, one register per cycle,
// to be used while the block is idle.
// The accepted word is written into the queue, read into the window stage,
// and its result is held in the output register; a byte is decided once the
// window is full or the string has ended. Throughput: one word per cycle
// while the string runs and the window stage is free; the rest of an escape
// sequence, the drain of the window at a string end and a receiver stall
// hold the stage. Input words queue up (4 deep) behind it.
// Reset clears the window, the queue and the output, and loads the default
// config: delimiter comma, escape backslash with escaping off.
// A receiver stall holds the result register; the window stage stops, the
// queue fills and in_ready drops.
module escaped_delimiter_splitter
  import eds_pkg::*;
#(
  parameter int NB    = MAX_PATTERN_BYTES,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data,
  input  logic       cfg_we,
  input  cfg_index_t cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t     cfg_r, cfg_nxt;
  logic     q_push, q_full, q_pop, q_not_empty;
  in_word_t q_in, q_out;

  // config register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DELIM_PATTERN:  cfg_nxt.delimiter_pattern = cfg_data;
        CFG_DELIM_LENGTH:   cfg_nxt.delimiter_length  = cfg_data[3:0];
        CFG_ESCAPE_PATTERN: cfg_nxt.escape_pattern    = cfg_data;
        CFG_ESCAPE_LENGTH:  cfg_nxt.escape_length     = cfg_data[3:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{delimiter_pattern: 64'd44, delimiter_length: 4'd1,
                 escape_pattern: 64'd92, escape_length: 4'd0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // accept and classify
  eds_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_in),
    .q_full   (q_full)
  );

  // decoupling queue
  eds_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  // window matching and results
  eds_back #(
    .NB (NB)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_not_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
